// ===== hw/rtl/mshe_pkg.sv =====
// Package for the multi-mode string hash engine: algorithm codes, configuration
// register indexes, hash constants, shared types and shift helpers.
// Depends on nothing; mshe_mix, mshe_fin and the top level use it.
`default_nettype none

package mshe_pkg;

  typedef enum logic [2:0] {
    MODE_OAT = 3'd0,
    MODE_FNV = 3'd1,
    MODE_RS  = 3'd2,
    MODE_JS  = 3'd3,
    MODE_ELF = 3'd4,
    MODE_AP  = 3'd5
  } mode_e;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 3;
  localparam logic [CfgIdxW-1:0] CFG_HASH_MODE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SIGNED_BYTES = 2'd1;

  localparam logic [31:0] MASK_OAT  = 32'h8765_fed1;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;
  localparam logic [31:0] FNV_SEED  = 32'd2166136261;
  localparam logic [31:0] RS_B      = 32'd378551;
  localparam logic [31:0] RS_A0     = 32'd63689;
  localparam logic [31:0] JS_SEED   = 32'd1315423911;
  localparam logic [31:0] ELF_TOP   = 32'hF000_0000;
  localparam logic [31:0] LOW31     = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [31:0] hash;
    logic [31:0] rs_mul;
    logic        odd;
  } mix_state_t;

  function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
    logic signed [31:0] s;
    s = $signed(x);
    return 32'(s >>> n);
  endfunction

  function automatic logic [31:0] seed_of(input logic [2:0] mode);
    logic [31:0] r;
    r = 32'd0;
    if (mode == MODE_FNV) r = FNV_SEED;
    if (mode == MODE_JS) r = JS_SEED;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mshe_if.sv =====
// Valid/ready stream interfaces for the hash engine: key bytes in, hash words out.
// Depends on nothing.
`default_nettype none

interface mshe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_byte;
  logic       last_byte;

  modport source (output valid, output key_byte, output last_byte, input ready);
  modport sink (input valid, input key_byte, input last_byte, output ready);
endinterface

interface mshe_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink (input valid, input hash_value, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mshe_mix.sv =====
// One mixing step of the selected hash algorithm applied to one key byte.
// Depends on mshe_pkg.
`default_nettype none

module mshe_mix (
  input  wire logic [2:0]           mode_i,
  input  wire logic                 key_start_i,
  input  wire logic [31:0]          char_i,
  input  wire mshe_pkg::mix_state_t state_i,
  output mshe_pkg::mix_state_t      state_o
);

  logic [31:0] h0;
  logic [31:0] rs0;
  logic        odd0;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] mul_p;
  logic [31:0] rs_next;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] elf_top;

  always_comb begin
    if (key_start_i) begin
      h0   = mshe_pkg::seed_of(mode_i);
      rs0  = mshe_pkg::RS_A0;
      odd0 = 1'b0;
    end else begin
      h0   = state_i.hash;
      rs0  = state_i.rs_mul;
      odd0 = state_i.odd;
    end
  end

  // The FNV and RS steps share one multiplier.
  assign mul_a   = (mode_i == mshe_pkg::MODE_FNV) ? (h0 ^ char_i) : h0;
  assign mul_b   = (mode_i == mshe_pkg::MODE_FNV) ? mshe_pkg::FNV_PRIME : rs0;
  assign mul_p   = mul_a * mul_b;
  assign rs_next = rs0 * mshe_pkg::RS_B;

  always_comb begin
    state_o.hash   = h0;
    state_o.rs_mul = rs0;
    state_o.odd    = odd0;
    t1             = '0;
    t2             = '0;
    elf_top        = '0;
    case (mode_i)
      mshe_pkg::MODE_OAT: begin
        t1 = h0 + char_i;
        t2 = t1 + (t1 << 10);
        state_o.hash = t2 ^ mshe_pkg::asr(t2, 6);
      end
      mshe_pkg::MODE_FNV: begin
        state_o.hash = mul_p;
      end
      mshe_pkg::MODE_RS: begin
        state_o.hash   = mul_p + char_i;
        state_o.rs_mul = rs_next;
      end
      mshe_pkg::MODE_JS: begin
        state_o.hash = h0 ^ ((h0 << 5) + char_i + mshe_pkg::asr(h0, 2));
      end
      mshe_pkg::MODE_ELF: begin
        t1 = (h0 << 4) + char_i;
        elf_top = t1 & mshe_pkg::ELF_TOP;
        state_o.hash = (t1 ^ mshe_pkg::asr(elf_top, 24)) & ~elf_top;
      end
      mshe_pkg::MODE_AP: begin
        if (!odd0) begin
          state_o.hash = h0 ^ ((h0 << 7) ^ char_i ^ mshe_pkg::asr(h0, 3));
        end else begin
          state_o.hash = h0 ^ ~((h0 << 11) ^ char_i ^ mshe_pkg::asr(h0, 5));
        end
        state_o.odd = ~odd0;
      end
      default: begin
        state_o.hash = h0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mshe_fin.sv =====
// Finalisation of a running hash into the delivered hash word.
// Depends on mshe_pkg.
`default_nettype none

module mshe_fin (
  input  wire logic [2:0]  mode_i,
  input  wire logic [31:0] hash_i,
  output logic [31:0]      hash_o
);

  logic [31:0] a;
  logic [31:0] b;
  logic [31:0] c;
  logic [31:0] d;

  always_comb begin
    a = '0;
    b = '0;
    c = '0;
    d = '0;
    case (mode_i)
      mshe_pkg::MODE_OAT: begin
        a = hash_i + (hash_i << 3);
        b = a ^ mshe_pkg::asr(a, 11);
        c = b + (b << 15);
        hash_o = c & mshe_pkg::MASK_OAT;
      end
      mshe_pkg::MODE_FNV: begin
        a = hash_i + (hash_i << 13);
        b = a ^ mshe_pkg::asr(a, 7);
        c = b + (b << 3);
        d = c ^ mshe_pkg::asr(c, 17);
        hash_o = d + (d << 5);
      end
      mshe_pkg::MODE_RS, mshe_pkg::MODE_JS, mshe_pkg::MODE_ELF: begin
        hash_o = hash_i & mshe_pkg::LOW31;
      end
      mshe_pkg::MODE_AP: begin
        hash_o = hash_i;
      end
      default: begin
        hash_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/multi_mode_string_hash_engine_top.sv =====
// Top level of the multi-mode string hash engine: input register, mixing step,
// finalisation stage and output register. Depends on mshe_pkg, mshe_if,
// mshe_mix and mshe_fin.
//
// Key bytes enter one per cycle unless a key's last byte waits in the input
// register for the finalisation register; other bytes are mixed into the
// running hash in the cycle after they are accepted. A key's hash goes from
// the finalisation register, finalised, to the output register. The hash loop
// through the mixing step (a 32-bit multiplier for FNV and RS) fixes the
// one-byte-per-cycle rate. Non-last bytes flow on while a hash waits at output.
// Configuration is to be written only while no key is in flight.
`default_nettype none

module multi_mode_string_hash_engine_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  mshe_in_if.sink                             key_in,
  mshe_out_if.source                          hash_out,
  input  wire logic                           cfg_we_i,
  input  wire logic [mshe_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [mshe_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  logic [2:0]  mode_q;
  logic        signed_q;

  logic        a_vld_q;
  logic [7:0]  a_byte_q;
  logic        a_last_q;

  mshe_pkg::mix_state_t st_q;
  mshe_pkg::mix_state_t st_d;
  logic        inside_q;

  logic        b_vld_q;
  logic [31:0] b_hash_q;
  logic [2:0]  b_mode_q;

  logic        o_vld_q;
  logic [31:0] o_hash_q;
  logic [31:0] fin_hash;

  logic        o_free;
  logic        b_go;
  logic        b_free;
  logic        a_go;
  logic        a_free;
  logic        in_acc;
  logic [31:0] char_ext;

  assign o_free = !o_vld_q || hash_out.ready;
  assign b_go   = b_vld_q && o_free;
  assign b_free = !b_vld_q || b_go;
  assign a_go   = a_vld_q && (!a_last_q || b_free);
  assign a_free = !a_vld_q || a_go;
  assign in_acc = key_in.valid && a_free;

  assign key_in.ready        = a_free;
  assign hash_out.valid      = o_vld_q;
  assign hash_out.hash_value = o_hash_q;

  assign char_ext = {{24{signed_q & a_byte_q[7]}}, a_byte_q};

  mshe_mix u_mix (
    .mode_i      (mode_q),
    .key_start_i (!inside_q),
    .char_i      (char_ext),
    .state_i     (st_q),
    .state_o     (st_d)
  );

  mshe_fin u_fin (
    .mode_i (b_mode_q),
    .hash_i (b_hash_q),
    .hash_o (fin_hash)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= mshe_pkg::MODE_OAT;
      signed_q  <= 1'b1;
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      o_vld_q   <= 1'b0;
      inside_q  <= 1'b0;
      st_q.hash   <= '0;
      st_q.rs_mul <= mshe_pkg::RS_A0;
      st_q.odd    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mshe_pkg::CFG_HASH_MODE:    mode_q   <= cfg_wdata_i[2:0];
          mshe_pkg::CFG_SIGNED_BYTES: signed_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (a_free) begin
        a_vld_q <= key_in.valid;
      end
      if (a_go) begin
        st_q     <= st_d;
        inside_q <= !a_last_q;
      end
      if (b_free) begin
        b_vld_q <= a_go && a_last_q;
      end
      if (o_free) begin
        o_vld_q <= b_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_byte_q <= key_in.key_byte;
      a_last_q <= key_in.last_byte;
    end
    if (a_go && a_last_q) begin
      b_hash_q <= st_d.hash;
      b_mode_q <= mode_q;
    end
    if (b_go) begin
      o_hash_q <= fin_hash;
    end
  end

endmodule

`default_nettype wire
